>>> design/hpe_pkg.sv
// ----------------------------------------------------------------------------
// hpe_pkg: shared types and constants for the horner polynomial evaluator
// widths of the fixed-point datapath, sequencer states and control strobes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hpe_pkg;

	// coefficient store
	localparam int MAX_TERMS = 32;
	localparam int ADDR_W    = $clog2(MAX_TERMS);

	// field widths
	localparam int DEG_W  = 5;
	localparam int IDX_W  = 5;
	localparam int COEF_W = 8;
	localparam int X_W    = 22;
	localparam int ACC_W  = 64;
	localparam int FRAC_W = 16;

	// split multiply: accumulator halves against x
	localparam int HALF_W  = ACC_W / 2;
	localparam int MUL_A_W = HALF_W + 1;
	localparam int PROD_W  = MUL_A_W + X_W;
	// shifted product plus coefficient, with headroom for the saturation check
	localparam int SUM_W   = ACC_W + X_W - FRAC_W + 1;

	// input item modes
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_EVAL = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_SEED,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_ACC,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic start;
		logic seed;
		logic mul_lo;
		logic mul_hi;
		logic acc_upd;
		logic emit;
	} ctl_t;

endpackage

>>> design/hpe_ram.sv
// ----------------------------------------------------------------------------
// hpe_ram: generic single-write, single-read ram
// one write port and one read port with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hpe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> design/hpe_datapath.sv
// ----------------------------------------------------------------------------
// hpe_datapath: accumulator and shared multiplier
// one signed 33x22 multiplier used twice per step, then shift, add, saturate
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hpe_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  hpe_pkg::ctl_t                    ctl,
	input  logic signed [hpe_pkg::X_W-1:0]   x_value,
	input  logic [hpe_pkg::COEF_W-1:0]       coef,
	output logic signed [hpe_pkg::ACC_W-1:0] acc,
	output logic                             ovf
);

	logic signed [hpe_pkg::X_W-1:0]     x_q;
	logic signed [hpe_pkg::ACC_W-1:0]   acc_q;
	logic signed [hpe_pkg::PROD_W-1:0]  plo_q;
	logic signed [hpe_pkg::PROD_W-1:0]  phi_q;
	logic                               ovf_q;

	logic signed [hpe_pkg::MUL_A_W-1:0] mul_a;
	logic signed [hpe_pkg::PROD_W-1:0]  prod;
	logic signed [hpe_pkg::PROD_W-1:0]  plo_sh;
	logic signed [hpe_pkg::SUM_W-1:0]   phi_ext;
	logic signed [hpe_pkg::SUM_W-1:0]   plo_ext;
	logic signed [hpe_pkg::SUM_W-1:0]   cof_ext;
	logic signed [hpe_pkg::SUM_W-1:0]   sum;
	logic [hpe_pkg::SUM_W-hpe_pkg::ACC_W:0] top_bits;
	logic                               sat;
	logic signed [hpe_pkg::ACC_W-1:0]   acc_nxt;
	logic [hpe_pkg::ACC_W-1:0]          seed_val;

	// low half unsigned, high half signed
	always_comb begin
		if (ctl.mul_hi) begin
			mul_a = {acc_q[hpe_pkg::ACC_W-1], acc_q[hpe_pkg::ACC_W-1 -: hpe_pkg::HALF_W]};
		end else begin
			mul_a = {1'b0, acc_q[hpe_pkg::HALF_W-1:0]};
		end
	end

	assign prod = mul_a * x_q;

	// (phi*2^32 + plo) >>> 16 == phi*2^16 + (plo >>> 16)
	assign plo_sh  = plo_q >>> hpe_pkg::FRAC_W;
	assign phi_ext = hpe_pkg::SUM_W'(phi_q) <<< hpe_pkg::FRAC_W;
	assign plo_ext = hpe_pkg::SUM_W'(plo_sh);
	assign cof_ext = $signed({{(hpe_pkg::SUM_W-hpe_pkg::COEF_W-hpe_pkg::FRAC_W){1'b0}},
		coef, {hpe_pkg::FRAC_W{1'b0}}});
	assign sum     = phi_ext + plo_ext + cof_ext;

	// fits in 64 bits only when all bits above bit 62 agree
	assign top_bits = sum[hpe_pkg::SUM_W-1:hpe_pkg::ACC_W-1];
	assign sat      = !((&top_bits) || !(|top_bits));

	always_comb begin
		if (!sat) begin
			acc_nxt = sum[hpe_pkg::ACC_W-1:0];
		end else if (sum[hpe_pkg::SUM_W-1]) begin
			acc_nxt = {1'b1, {(hpe_pkg::ACC_W-1){1'b0}}};
		end else begin
			acc_nxt = {1'b0, {(hpe_pkg::ACC_W-1){1'b1}}};
		end
	end

	assign seed_val = {{(hpe_pkg::ACC_W-hpe_pkg::COEF_W-hpe_pkg::FRAC_W){1'b0}},
		coef, {hpe_pkg::FRAC_W{1'b0}}};

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			x_q <= x_value;
		end
		if (ctl.mul_lo) begin
			plo_q <= prod;
		end
		if (ctl.mul_hi) begin
			phi_q <= prod;
		end
		if (ctl.seed) begin
			acc_q <= seed_val;
		end else if (ctl.acc_upd) begin
			acc_q <= acc_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovf_q <= 1'b0;
		end else if (ctl.start) begin
			ovf_q <= 1'b0;
		end else if (ctl.acc_upd && sat) begin
			ovf_q <= 1'b1;
		end
	end

	assign acc = acc_q;
	assign ovf = ovf_q;

endmodule

>>> design/hpe_ctrl.sv
// ----------------------------------------------------------------------------
// hpe_ctrl: evaluation sequencer
// walks coefficients from the degree down to zero: mul_lo, mul_hi, acc a step
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hpe_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [hpe_pkg::DEG_W-1:0]   degree,
	input  logic                        out_free,
	output hpe_pkg::ctl_t               ctl,
	output logic [hpe_pkg::ADDR_W-1:0]  raddr,
	output logic                        idle
);

	hpe_pkg::state_t                state_q;
	hpe_pkg::state_t                state_nxt;
	logic [hpe_pkg::ADDR_W-1:0]     n_q;
	logic [hpe_pkg::ADDR_W-1:0]     n_init;
	logic                           last;

	// clamp degree to the store
	always_comb begin
		if (32'(degree) > hpe_pkg::MAX_TERMS - 1) begin
			n_init = hpe_pkg::ADDR_W'(hpe_pkg::MAX_TERMS - 1);
		end else begin
			n_init = hpe_pkg::ADDR_W'(degree);
		end
	end

	assign last = (n_q == '0);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			hpe_pkg::ST_IDLE:   if (start) state_nxt = hpe_pkg::ST_FETCH;
			hpe_pkg::ST_FETCH:  state_nxt = hpe_pkg::ST_SEED;
			hpe_pkg::ST_SEED:   state_nxt = last ? hpe_pkg::ST_DONE : hpe_pkg::ST_MUL_LO;
			hpe_pkg::ST_MUL_LO: state_nxt = hpe_pkg::ST_MUL_HI;
			hpe_pkg::ST_MUL_HI: state_nxt = hpe_pkg::ST_ACC;
			hpe_pkg::ST_ACC:    state_nxt = last ? hpe_pkg::ST_DONE : hpe_pkg::ST_MUL_LO;
			hpe_pkg::ST_DONE:   if (out_free) state_nxt = hpe_pkg::ST_IDLE;
			default:            state_nxt = hpe_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		ctl         = '0;
		ctl.start   = start && (state_q == hpe_pkg::ST_IDLE);
		idle        = 1'b0;
		case (state_q)
			hpe_pkg::ST_IDLE:   idle = 1'b1;
			hpe_pkg::ST_SEED:   ctl.seed = 1'b1;
			hpe_pkg::ST_MUL_LO: ctl.mul_lo = 1'b1;
			hpe_pkg::ST_MUL_HI: ctl.mul_hi = 1'b1;
			hpe_pkg::ST_ACC:    ctl.acc_upd = 1'b1;
			hpe_pkg::ST_DONE:   ctl.emit = out_free;
			default:            idle = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hpe_pkg::ST_IDLE;
			n_q     <= '0;
		end else begin
			state_q <= state_nxt;
			if (ctl.start) begin
				n_q <= n_init;
			end else if ((ctl.seed || ctl.acc_upd) && !last) begin
				n_q <= n_q - 1'b1;
			end
		end
	end

	// coefficient index read ahead of its use
	assign raddr = n_q;

	a_step_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == hpe_pkg::ST_MUL_LO |=> state_q == hpe_pkg::ST_MUL_HI ##1
			state_q == hpe_pkg::ST_ACC)
		else $error("multiply step out of order");

	a_one_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.seed, ctl.mul_lo, ctl.mul_hi, ctl.acc_upd, ctl.emit}))
		else $error("more than one datapath strobe");

	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.acc_upd && !last |=> n_q == $past(n_q) - 1'b1)
		else $error("coefficient index did not step down");

	a_start_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |=> state_q == hpe_pkg::ST_FETCH && n_q == $past(n_init))
		else $error("evaluation start not taken");

endmodule

>>> design/horner_polynomial_eval_core.sv
// ----------------------------------------------------------------------------
// horner_polynomial_eval_core: fixed-point polynomial evaluator, horner's rule
// input transactions with mode 0 load coefficient coeff_value at coeff_index;
// mode 1 evaluates the polynomial of cfg degree at x_value (signed Q6.16) and
// returns poly_value (signed Q48.16, saturated) with a sticky overflow flag.
// both channels use valid/stall; a transaction moves when valid is high and
// stall is low. a load writes the coefficient store and returns nothing.
// an evaluation keeps in_stall high from the edge that takes it until the core
// is back in idle (fetch, seed, then per step a low and a high multiply on one
// shared 33x22 multiplier and a shift/add/saturate state, then done), so no
// new transaction is taken before the previous evaluation has finished.
// the result is written from the done state into an output register.
// if the receiver stalls, the result holds there and the core
// waits in its done state, while the next transaction can still be taken
// once the previous result has been moved into that register.
// reset clears the sequencer, the output valid and degree to 0; the
// coefficient store is not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module horner_polynomial_eval_core (
	input  logic                             clk,
	input  logic                             arst_n,
	// config
	input  logic                             cfg_wr_en,
	input  logic [hpe_pkg::DEG_W-1:0]        cfg_wr_data,
	// input channel
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             mode,
	input  logic [hpe_pkg::IDX_W-1:0]        coeff_index,
	input  logic [hpe_pkg::COEF_W-1:0]       coeff_value,
	input  logic signed [hpe_pkg::X_W-1:0]   x_value,
	// output channel
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [hpe_pkg::ACC_W-1:0] poly_value,
	output logic                             overflow
);

	logic [hpe_pkg::DEG_W-1:0]        degree_q;
	logic                             out_valid_q;
	logic signed [hpe_pkg::ACC_W-1:0] poly_value_q;
	logic                             overflow_q;

	logic                             in_acc;
	logic                             load_we;
	logic                             eval_start;
	logic                             out_free;
	logic                             idle;
	hpe_pkg::ctl_t                    ctl;
	logic [hpe_pkg::ADDR_W-1:0]       raddr;
	logic [hpe_pkg::COEF_W-1:0]       coef;
	logic signed [hpe_pkg::ACC_W-1:0] acc;
	logic                             ovf;

	// input handshake: open only while the sequencer is idle
	assign in_stall   = !idle;
	assign in_acc     = in_valid && !in_stall;
	assign eval_start = in_acc && (mode == hpe_pkg::MODE_EVAL);
	// loads outside the store are dropped
	assign load_we    = in_acc && (mode == hpe_pkg::MODE_LOAD) &&
		(32'(coeff_index) < hpe_pkg::MAX_TERMS);

	// output register is free when empty or being drained this cycle
	assign out_free = !out_valid_q || !out_stall;

	// degree register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q <= '0;
		end else if (cfg_wr_en) begin
			degree_q <= cfg_wr_data;
		end
	end

	// coefficient store
	hpe_ram #(
		.WIDTH (hpe_pkg::COEF_W),
		.DEPTH (hpe_pkg::MAX_TERMS)
	) u_coef_ram (
		.clk   (clk),
		.we    (load_we),
		.waddr (hpe_pkg::ADDR_W'(coeff_index)),
		.wdata (coeff_value),
		.raddr (raddr),
		.rdata (coef)
	);

	hpe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (eval_start),
		.degree   (degree_q),
		.out_free (out_free),
		.ctl      (ctl),
		.raddr    (raddr),
		.idle     (idle)
	);

	hpe_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.x_value (x_value),
		.coef    (coef),
		.acc     (acc),
		.ovf     (ovf)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			poly_value_q <= acc;
			overflow_q   <= ovf;
		end
	end

	assign out_valid  = out_valid_q;
	assign poly_value = poly_value_q;
	assign overflow   = overflow_q;

	a_busy_after_eval: assert property (@(posedge clk) disable iff (!arst_n)
		eval_start |=> in_stall)
		else $error("input open right after an evaluation started");

	a_no_load_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		load_we |-> idle && !ctl.emit)
		else $error("coefficient write during an evaluation");

	a_emit_into_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |-> !(out_valid_q && out_stall))
		else $error("result written over a stalled result");

endmodule
